FILE: rtl/elp_pkg.sv
// Package for the epoch literal parser: shared types and constants.
// No dependencies.
package elp_pkg;

    localparam int unsigned MAG_BITS = 64;
    localparam int unsigned NS_BITS  = 30;
    localparam int unsigned CNT_BITS = 4;

    localparam logic [7:0] CH_AT    = 8'd64;
    localparam logic [7:0] CH_PLUS  = 8'd43;
    localparam logic [7:0] CH_MINUS = 8'd45;
    localparam logic [7:0] CH_DOT   = 8'd46;
    localparam logic [7:0] CH_SPACE = 8'd32;
    localparam logic [7:0] CH_TAB   = 8'd9;
    localparam logic [7:0] CH_CR    = 8'd13;
    localparam logic [7:0] CH_ZERO  = 8'd48;
    localparam logic [7:0] CH_NINE  = 8'd57;

    localparam logic [CNT_BITS-1:0] FRAC_DIGITS = 4'd9;

    localparam logic [MAG_BITS-1:0] MAG_CAP       = 64'h8000_0000_0000_0000;
    localparam logic [MAG_BITS-1:0] MAG_CAP_DIV10 = 64'd922337203685477580;
    localparam logic [NS_BITS-1:0]  NS_PER_S      = 30'd1000000000;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_SYNTAX    = 2'd1;
    localparam logic [1:0] ST_RANGE     = 2'd2;
    localparam logic [1:0] ST_NEG_FRAC  = 2'd3;

    localparam logic [0:0] CFG_TRAIL_SPACE = 1'b0;
    localparam logic [0:0] CFG_NORM_NEG    = 1'b1;

    // Everything the end-of-literal stage needs from the parser
    typedef struct packed {
        logic                overflowed;
        logic                syntax_ok;
        logic                is_negative;
        logic [MAG_BITS-1:0] magnitude;
        logic [NS_BITS-1:0]  fraction;
        logic [CNT_BITS-1:0] frac_count;
    } fin_t;

    // 10^(9 - count): scale for padding a short fraction
    function automatic logic [NS_BITS-1:0] pad_scale(input logic [CNT_BITS-1:0] cnt);
        logic [NS_BITS-1:0] s;
        begin
            case (cnt)
                4'd0:    s = 30'd1000000000;
                4'd1:    s = 30'd100000000;
                4'd2:    s = 30'd10000000;
                4'd3:    s = 30'd1000000;
                4'd4:    s = 30'd100000;
                4'd5:    s = 30'd10000;
                4'd6:    s = 30'd1000;
                4'd7:    s = 30'd100;
                4'd8:    s = 30'd10;
                default: s = 30'd1;
            endcase
            return s;
        end
    endfunction

endpackage

FILE: rtl/elp_parse.sv
// Character parser: phase machine, integer/fraction accumulation, end-of-literal register.
// Depends on elp_pkg.
module elp_parse
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [7:0]       char_code,
    input  logic             last_char,
    input  logic             allow_trail,
    output logic             fin_valid,
    input  logic             fin_ready,
    output elp_pkg::fin_t    fin
);

    localparam logic [2:0] PH_AT     = 3'd0;
    localparam logic [2:0] PH_PRE    = 3'd1;
    localparam logic [2:0] PH_SIGNED = 3'd2;
    localparam logic [2:0] PH_INT    = 3'd3;
    localparam logic [2:0] PH_DOT    = 3'd4;
    localparam logic [2:0] PH_FRAC   = 3'd5;
    localparam logic [2:0] PH_TRAIL  = 3'd6;
    localparam logic [2:0] PH_ERR    = 3'd7;

    logic [2:0]                          phase_reg, phase_next;
    logic                                neg_reg, neg_next;
    logic [elp_pkg::MAG_BITS-1:0]        mag_reg, mag_next;
    logic                                ovf_reg, ovf_next;
    logic [elp_pkg::NS_BITS-1:0]         frac_reg, frac_next;
    logic [elp_pkg::CNT_BITS-1:0]        cnt_reg, cnt_next;
    logic                                fin_valid_reg;
    elp_pkg::fin_t                       fin_reg, fin_next;

    logic                                is_space, is_digit, accept;
    logic [3:0]                          digit;
    logic [elp_pkg::MAG_BITS-1:0]        mag_sum;
    logic                                int_ovf;
    logic [elp_pkg::NS_BITS-1:0]         frac_sum;

    assign accept   = in_valid && in_ready;
    assign in_ready = !fin_valid_reg || fin_ready;
    assign is_space = (char_code inside {[elp_pkg::CH_TAB:elp_pkg::CH_CR], elp_pkg::CH_SPACE});
    assign is_digit = (char_code inside {[elp_pkg::CH_ZERO:elp_pkg::CH_NINE]});
    assign digit    = char_code[3:0];

    // mag*10 + d; only taken when mag <= cap/10, so no wrap
    assign mag_sum = {mag_reg[elp_pkg::MAG_BITS-4:0], 3'b000}
                   + {mag_reg[elp_pkg::MAG_BITS-2:0], 1'b0}
                   + {{(elp_pkg::MAG_BITS-4){1'b0}}, digit};
    assign int_ovf = (mag_reg > elp_pkg::MAG_CAP_DIV10) || (mag_sum > elp_pkg::MAG_CAP);

    assign frac_sum = {frac_reg[elp_pkg::NS_BITS-4:0], 3'b000}
                    + {frac_reg[elp_pkg::NS_BITS-2:0], 1'b0}
                    + {{(elp_pkg::NS_BITS-4){1'b0}}, digit};

    always_comb
    begin
        logic take_int;
        logic take_frac;
        take_int   = 1'b0;
        take_frac  = 1'b0;
        phase_next = PH_ERR;
        neg_next   = neg_reg;
        case (phase_reg)
            PH_AT:
            begin
                phase_next = (char_code == elp_pkg::CH_AT) ? PH_PRE : PH_ERR;
            end
            PH_PRE:
            begin
                if (is_space)
                begin
                    phase_next = PH_PRE;
                end
                else if (char_code == elp_pkg::CH_PLUS)
                begin
                    phase_next = PH_SIGNED;
                end
                else if (char_code == elp_pkg::CH_MINUS)
                begin
                    phase_next = PH_SIGNED;
                    neg_next   = 1'b1;
                end
                else if (is_digit)
                begin
                    phase_next = PH_INT;
                    take_int   = 1'b1;
                end
            end
            PH_SIGNED:
            begin
                if (is_digit)
                begin
                    phase_next = PH_INT;
                    take_int   = 1'b1;
                end
            end
            PH_INT:
            begin
                if (is_digit)
                begin
                    phase_next = PH_INT;
                    take_int   = 1'b1;
                end
                else if (char_code == elp_pkg::CH_DOT)
                begin
                    phase_next = PH_DOT;
                end
                else if (allow_trail && is_space)
                begin
                    phase_next = PH_TRAIL;
                end
            end
            PH_DOT, PH_FRAC:
            begin
                if (is_digit)
                begin
                    phase_next = PH_FRAC;
                    take_frac  = 1'b1;
                end
                else if (phase_reg == PH_FRAC && allow_trail && is_space)
                begin
                    phase_next = PH_TRAIL;
                end
            end
            PH_TRAIL:
            begin
                phase_next = (allow_trail && is_space) ? PH_TRAIL : PH_ERR;
            end
            default:
            begin
                phase_next = PH_ERR;
            end
        endcase

        ovf_next = ovf_reg;
        mag_next = mag_reg;
        if (take_int && !ovf_reg)
        begin
            if (int_ovf)
            begin
                ovf_next = 1'b1;
            end
            else
            begin
                mag_next = mag_sum;
            end
        end

        frac_next = frac_reg;
        cnt_next  = cnt_reg;
        if (take_frac && cnt_reg < elp_pkg::FRAC_DIGITS)
        begin
            frac_next = frac_sum;
            cnt_next  = cnt_reg + 4'd1;
        end

        fin_next.overflowed  = ovf_next;
        fin_next.syntax_ok   = (phase_next == PH_INT) || (phase_next == PH_FRAC)
                            || (phase_next == PH_TRAIL);
        fin_next.is_negative = neg_next;
        fin_next.magnitude   = mag_next;
        fin_next.fraction    = frac_next;
        fin_next.frac_count  = cnt_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_AT;
            neg_reg       <= 1'b0;
            mag_reg       <= '0;
            ovf_reg       <= 1'b0;
            frac_reg      <= '0;
            cnt_reg       <= '0;
            fin_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                if (last_char)
                begin
                    phase_reg <= PH_AT;
                    neg_reg   <= 1'b0;
                    mag_reg   <= '0;
                    ovf_reg   <= 1'b0;
                    frac_reg  <= '0;
                    cnt_reg   <= '0;
                end
                else
                begin
                    phase_reg <= phase_next;
                    neg_reg   <= neg_next;
                    mag_reg   <= mag_next;
                    ovf_reg   <= ovf_next;
                    frac_reg  <= frac_next;
                    cnt_reg   <= cnt_next;
                end
            end
            if (accept && last_char)
            begin
                fin_valid_reg <= 1'b1;
            end
            else if (fin_ready)
            begin
                fin_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && last_char)
        begin
            fin_reg <= fin_next;
        end
    end

    assign fin_valid = fin_valid_reg;
    assign fin       = fin_reg;

endmodule

FILE: rtl/elp_finish.sv
// End-of-literal stage: fraction padding, sign handling, range check, result register.
// Depends on elp_pkg.
module elp_finish
#(
    parameter int SECONDS_BITS = 64
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         fin_valid,
    output logic                         fin_ready,
    input  elp_pkg::fin_t                fin,
    input  logic                         norm_neg,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [1:0]                   status,
    output logic [63:0]                  seconds,
    output logic [elp_pkg::NS_BITS-1:0]  nanoseconds
);

    localparam logic [63:0] HALF = 64'd1 << (SECONDS_BITS - 1);

    logic                         out_valid_reg;
    logic [1:0]                   status_reg, status_next;
    logic [63:0]                  sec_reg, sec_next;
    logic [elp_pkg::NS_BITS-1:0]  ns_reg, ns_next;

    logic [2*elp_pkg::NS_BITS-1:0] ns_prod;
    logic [elp_pkg::NS_BITS-1:0]   ns_pad;
    logic                          neg, borrow, too_big;

    assign fin_ready = !out_valid_reg || out_ready;

    assign ns_prod = fin.fraction * elp_pkg::pad_scale(fin.frac_count);
    assign ns_pad  = ns_prod[elp_pkg::NS_BITS-1:0];
    assign neg     = fin.is_negative && (fin.magnitude != 64'd0);
    assign borrow  = neg && (ns_pad != '0);
    // borrowing adds one to the magnitude, so the negative limit tightens by one
    assign too_big = (neg && !borrow) ? (fin.magnitude > HALF) : (fin.magnitude >= HALF);

    always_comb
    begin
        status_next = elp_pkg::ST_OK;
        sec_next    = '0;
        ns_next     = '0;
        if (fin.overflowed)
        begin
            status_next = elp_pkg::ST_RANGE;
        end
        else if (!fin.syntax_ok)
        begin
            status_next = elp_pkg::ST_SYNTAX;
        end
        else if (borrow && !norm_neg)
        begin
            status_next = elp_pkg::ST_NEG_FRAC;
        end
        else if (too_big)
        begin
            status_next = elp_pkg::ST_RANGE;
        end
        else
        begin
            // -(m+1) is ~m
            if (borrow)
            begin
                sec_next = ~fin.magnitude;
                ns_next  = elp_pkg::NS_PER_S - ns_pad;
            end
            else if (neg)
            begin
                sec_next = 64'd0 - fin.magnitude;
                ns_next  = ns_pad;
            end
            else
            begin
                sec_next = fin.magnitude;
                ns_next  = ns_pad;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (fin_valid && fin_ready)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fin_valid && fin_ready)
        begin
            status_reg <= status_next;
            sec_reg    <= sec_next;
            ns_reg     <= ns_next;
        end
    end

    assign out_valid   = out_valid_reg;
    assign status      = status_reg;
    assign seconds     = sec_reg;
    assign nanoseconds = ns_reg;

endmodule

FILE: rtl/epoch_literal_parser.sv
// Top level of the epoch literal parser: configuration registers, parser and result stage.
// Depends on elp_pkg, elp_parse, elp_finish.
//
//  channel | signals                          | word
//  in      | in_valid/in_ready                | char_code, last_char
//  out     | out_valid/out_ready              | status, seconds, nanoseconds
//  cfg     | cfg_we, cfg_index, cfg_data      | one register bit
//
// One character accepted per cycle while in_ready is high; the parser state
// updates at acceptance. The word for a final character passes a finish
// register, then the result register that drives out_valid.
// Reset clears the parser, both valid flags and the configuration bits.
// A held result stalls the finish register, which then stalls the input.
module epoch_literal_parser
#(
    parameter int SECONDS_BITS = 64
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         in_valid,
    output logic         in_ready,
    input  logic [7:0]   char_code,
    input  logic         last_char,
    output logic         out_valid,
    input  logic         out_ready,
    output logic [1:0]   status,
    output logic [63:0]  seconds,
    output logic [29:0]  nanoseconds,
    input  logic         cfg_we,
    input  logic         cfg_index,
    input  logic         cfg_data
);

    logic           allow_trail_reg;
    logic           norm_neg_reg;
    logic           fin_valid;
    logic           fin_ready;
    elp_pkg::fin_t  fin;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            allow_trail_reg <= 1'b0;
            norm_neg_reg    <= 1'b0;
        end
        else if (cfg_we)
        begin
            if (cfg_index == elp_pkg::CFG_TRAIL_SPACE[0])
            begin
                allow_trail_reg <= cfg_data;
            end
            else
            begin
                norm_neg_reg <= cfg_data;
            end
        end
    end

    elp_parse u_parse
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .char_code   (char_code),
        .last_char   (last_char),
        .allow_trail (allow_trail_reg),
        .fin_valid   (fin_valid),
        .fin_ready   (fin_ready),
        .fin         (fin)
    );

    elp_finish #(
        .SECONDS_BITS (SECONDS_BITS)
    ) u_finish
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .fin_valid   (fin_valid),
        .fin_ready   (fin_ready),
        .fin         (fin),
        .norm_neg    (norm_neg_reg),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .status      (status),
        .seconds     (seconds),
        .nanoseconds (nanoseconds)
    );

endmodule

FILE: verif/tb_top.sv
// Testbench for epoch_literal_parser: streams '@seconds[.fraction]' literals one character per
// word and checks each result against a cycle-free predictor of the parser.
// Depends on elp_pkg and the epoch_literal_parser RTL.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int          SEC_BITS = 64;
    localparam logic [63:0] SEC_HALF = 64'd1 << (SEC_BITS - 1);

    typedef enum logic [2:0] {
        P_WANT_AT, P_LEAD, P_SIGN, P_WHOLE, P_POINT, P_FRAC, P_TAIL, P_BAD
    } phase_t;

    typedef enum int {RX_FREE, RX_COIN, RX_SPARSE} rx_mode_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [63:0] secs;
        logic [29:0] nsec;
    } stamp_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [7:0]  char_code = 8'd0;
    logic        last_char = 1'b0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [1:0]  status;
    logic [63:0] seconds;
    logic [29:0] nanoseconds;
    logic        cfg_we = 1'b0;
    logic        cfg_index = 1'b0;
    logic        cfg_data = 1'b0;

    // predictor state
    logic        cfg_trail = 1'b0;
    logic        cfg_norm = 1'b0;
    phase_t      ph = P_WANT_AT;
    logic        neg_sign = 1'b0;
    logic [63:0] mag_acc = '0;
    logic        mag_ovf = 1'b0;
    logic [29:0] frac_acc = '0;
    int          frac_cnt = 0;

    stamp_t      stamps_due[$];
    stamp_t      next_stamp;
    logic [7:0]  lit_buf[$];
    int          mismatches = 0;
    int          chars_sent = 0;
    int          tx_burst = 0;
    rx_mode_t    rx_mode = RX_FREE;
    int          rx_span = 0;
    string       limit_mags[8] = '{
        "9223372036854775807", "9223372036854775808", "9223372036854775809",
        "922337203685477580", "922337203685477581", "18446744073709551616",
        "0", "000000000000000000000001"
    };

    epoch_literal_parser #(.SECONDS_BITS(SEC_BITS)) u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .char_code  (char_code),
        .last_char  (last_char),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .status     (status),
        .seconds    (seconds),
        .nanoseconds(nanoseconds),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic logic is_blank(input logic [7:0] c);
        return c == elp_pkg::CH_SPACE || (c >= elp_pkg::CH_TAB && c <= elp_pkg::CH_CR);
    endfunction

    function automatic logic is_num(input logic [7:0] c);
        return c >= elp_pkg::CH_ZERO && c <= elp_pkg::CH_NINE;
    endfunction

    function automatic void add_whole(input logic [7:0] c);
        logic [63:0] nxt;
        if (mag_ovf)
            return;
        if (mag_acc > elp_pkg::MAG_CAP_DIV10)
        begin
            mag_ovf = 1'b1;
            return;
        end
        nxt = mag_acc * 64'd10 + 64'(c - elp_pkg::CH_ZERO);
        if (nxt > elp_pkg::MAG_CAP)
            mag_ovf = 1'b1;
        else
            mag_acc = nxt;
    endfunction

    function automatic void add_frac(input logic [7:0] c);
        if (frac_cnt < int'(elp_pkg::FRAC_DIGITS))
        begin
            frac_acc = frac_acc * 30'd10 + 30'(c - elp_pkg::CH_ZERO);
            frac_cnt++;
        end
    endfunction

    function automatic stamp_t close_literal();
        stamp_t      r;
        logic [63:0] mag;
        logic [31:0] ns;
        logic        neg;
        int          k;
        r = '{status: elp_pkg::ST_OK, secs: 64'd0, nsec: 30'd0};
        mag = mag_acc;
        ns = 32'(frac_acc);
        if (mag_ovf)
            r.status = elp_pkg::ST_RANGE;
        else if (!(ph inside {P_WHOLE, P_FRAC, P_TAIL}))
            r.status = elp_pkg::ST_SYNTAX;
        else
        begin
            for (k = frac_cnt; k < int'(elp_pkg::FRAC_DIGITS); k++)
                ns = ns * 32'd10;
            neg = neg_sign && mag != 64'd0;
            if (neg && ns != 32'd0)
            begin
                if (!cfg_norm)
                    r.status = elp_pkg::ST_NEG_FRAC;
                else if (mag >= SEC_HALF)
                    r.status = elp_pkg::ST_RANGE;
                else
                begin
                    mag = mag + 64'd1;
                    ns = 32'(elp_pkg::NS_PER_S) - ns;
                end
            end
            if (r.status == elp_pkg::ST_OK)
            begin
                if (neg ? (mag > SEC_HALF) : (mag > SEC_HALF - 64'd1))
                    r.status = elp_pkg::ST_RANGE;
                else
                begin
                    r.secs = neg ? (64'd0 - mag) : mag;
                    r.nsec = ns[29:0];
                end
            end
        end
        return r;
    endfunction

    function automatic void take_char(input logic [7:0] c, input logic fin);
        case (ph)
            P_WANT_AT:
                ph = (c == elp_pkg::CH_AT) ? P_LEAD : P_BAD;
            P_LEAD, P_SIGN:
            begin
                if (ph == P_LEAD && is_blank(c))
                    ph = P_LEAD;
                else if (ph == P_LEAD && c == elp_pkg::CH_PLUS)
                    ph = P_SIGN;
                else if (ph == P_LEAD && c == elp_pkg::CH_MINUS)
                begin
                    neg_sign = 1'b1;
                    ph = P_SIGN;
                end
                else if (is_num(c))
                begin
                    add_whole(c);
                    ph = P_WHOLE;
                end
                else
                    ph = P_BAD;
            end
            P_WHOLE:
            begin
                if (is_num(c))
                    add_whole(c);
                else if (c == elp_pkg::CH_DOT)
                    ph = P_POINT;
                else if (cfg_trail && is_blank(c))
                    ph = P_TAIL;
                else
                    ph = P_BAD;
            end
            P_POINT, P_FRAC:
            begin
                if (is_num(c))
                begin
                    add_frac(c);
                    ph = P_FRAC;
                end
                else if (ph == P_FRAC && cfg_trail && is_blank(c))
                    ph = P_TAIL;
                else
                    ph = P_BAD;
            end
            P_TAIL:
                ph = (cfg_trail && is_blank(c)) ? P_TAIL : P_BAD;
            default:
                ph = P_BAD;
        endcase
        if (fin)
        begin
            stamps_due.push_back(close_literal());
            ph = P_WANT_AT;
            neg_sign = 1'b0;
            mag_acc = '0;
            mag_ovf = 1'b0;
            frac_acc = '0;
            frac_cnt = 0;
        end
    endfunction

    always @(posedge clk)
    begin
        if (rst_n && in_valid && in_ready)
            take_char(char_code, last_char);
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (stamps_due.size() == 0)
            begin
                $error("unexpected result: status %0d seconds %0d", status, $signed(seconds));
                mismatches++;
            end
            else
            begin
                next_stamp = stamps_due.pop_front();
                if (status !== next_stamp.status)
                begin
                    $error("status: expected %0d, got %0d", next_stamp.status, status);
                    mismatches++;
                end
                if (seconds !== next_stamp.secs)
                begin
                    $error("seconds: expected %0d, got %0d",
                           $signed(next_stamp.secs), $signed(seconds));
                    mismatches++;
                end
                if (nanoseconds !== next_stamp.nsec)
                begin
                    $error("nanoseconds: expected %0d, got %0d", next_stamp.nsec, nanoseconds);
                    mismatches++;
                end
            end
        end
    end

    // receiver back-pressure: free-running, coin-flip or sparse ready
    always @(posedge clk)
    begin
        if (rx_span == 0)
        begin
            rx_mode <= rx_mode_t'($urandom_range(0, 2));
            rx_span <= $urandom_range(50, 400);
        end
        else
            rx_span <= rx_span - 1;
        case (rx_mode)
            RX_FREE:   out_ready <= 1'b1;
            RX_COIN:   out_ready <= 1'($urandom_range(0, 1));
            default:   out_ready <= ($urandom_range(0, 7) == 0);
        endcase
    end

    task automatic send_char(input logic [7:0] c, input logic fin);
        if (tx_burst == 0)
        begin
            tx_burst = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
                                                   : $urandom_range(1, 12);
            if ($urandom_range(0, 4) != 0)
            begin
                in_valid <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge clk);
            end
        end
        tx_burst--;
        in_valid  <= 1'b1;
        char_code <= c;
        last_char <= fin;
        chars_sent++;
        do
            @(posedge clk);
        while (!in_ready);
    endtask

    task automatic send_buf();
        int i;
        for (i = 0; i < lit_buf.size(); i++)
            send_char(lit_buf[i], i == lit_buf.size() - 1);
    endtask

    function automatic void push_text(input string s);
        int i;
        for (i = 0; i < s.len(); i++)
            lit_buf.push_back(s[i]);
    endfunction

    task automatic send_text(input string s);
        lit_buf.delete();
        push_text(s);
        send_buf();
    endtask

    task automatic wait_for_results();
        in_valid <= 1'b0;
        @(posedge clk);
        while (stamps_due.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic set_config(input logic trail, input logic norm);
        wait_for_results();
        cfg_we    <= 1'b1;
        cfg_index <= elp_pkg::CFG_TRAIL_SPACE[0];
        cfg_data  <= trail;
        @(posedge clk);
        cfg_index <= elp_pkg::CFG_NORM_NEG[0];
        cfg_data  <= norm;
        @(posedge clk);
        cfg_we    <= 1'b0;
        cfg_trail = trail;
        cfg_norm  = norm;
        @(posedge clk);
    endtask

    function automatic logic [7:0] any_blank();
        int n;
        n = $urandom_range(8, 13);
        return (n == 8) ? elp_pkg::CH_SPACE : 8'(n);
    endfunction

    function automatic void push_digits(input int n);
        repeat (n) lit_buf.push_back(elp_pkg::CH_ZERO + 8'($urandom_range(0, 9)));
    endfunction

    // mostly well-formed literals with random content; some damaged, some pure noise
    function automatic void build_literal();
        int kind;
        int pos;
        lit_buf.delete();
        kind = $urandom_range(0, 19);
        if (kind == 0)
        begin
            repeat ($urandom_range(1, 6)) lit_buf.push_back(8'($urandom_range(0, 255)));
            return;
        end
        lit_buf.push_back(elp_pkg::CH_AT);
        repeat (($urandom_range(0, 3) == 0) ? $urandom_range(1, 2) : 0)
            lit_buf.push_back(any_blank());
        case ($urandom_range(0, 2))
            0: lit_buf.push_back(elp_pkg::CH_PLUS);
            1: lit_buf.push_back(elp_pkg::CH_MINUS);
            default: ;
        endcase
        if ($urandom_range(0, 7) == 0)
            push_text(limit_mags[$urandom_range(0, 7)]);
        else
            push_digits(($urandom_range(0, 9) == 0) ? $urandom_range(15, 22)
                                                    : $urandom_range(1, 5));
        if ($urandom_range(0, 1) == 1)
        begin
            lit_buf.push_back(elp_pkg::CH_DOT);
            if ($urandom_range(0, 5) == 0)
                repeat ($urandom_range(1, 10)) lit_buf.push_back(elp_pkg::CH_ZERO);
            else
                push_digits(($urandom_range(0, 3) == 0) ? $urandom_range(10, 13)
                                                        : $urandom_range(1, 9));
        end
        if ($urandom_range(0, 3) == 0)
            repeat ($urandom_range(1, 2)) lit_buf.push_back(any_blank());
        if (kind <= 3)
        begin
            pos = $urandom_range(0, lit_buf.size() - 1);
            case ($urandom_range(0, 2))
                0: lit_buf[pos] = 8'($urandom_range(0, 255));
                1: lit_buf = lit_buf[0:pos];
                default: lit_buf.insert(pos, 8'($urandom_range(0, 255)));
            endcase
        end
    endfunction

    task automatic test_well_formed();
        send_text("@0");
        send_text("@+12.5");
        send_text("@\t\n -7");
        send_text("@1.123456789123");
        send_text("@-0.25");
        send_text("@00042.000000001");
    endtask

    task automatic test_syntax_errors();
        send_text("@");
        send_text("@-");
        send_text("@1.");
        send_text("#5");
        send_text("@+-1");
        send_text("@1 ");
        send_char(elp_pkg::CH_AT, 1'b0);
        send_char(8'h00, 1'b1);
        send_char(elp_pkg::CH_AT, 1'b0);
        send_char(8'hFF, 1'b1);
    endtask

    task automatic test_range();
        send_text("@9223372036854775807");
        send_text("@9223372036854775808");
        send_text("@-9223372036854775808");
        send_text("@-9223372036854775809");
        send_text("@99999999999999999999x");
    endtask

    task automatic test_negative_fraction();
        send_text("@-1.5");
        set_config(1'b0, 1'b1);
        send_text("@-1.5");
        send_text("@-9223372036854775807.5");
        send_text("@-9223372036854775808.1");
        send_text("@-3.000");
    endtask

    task automatic test_trailing_space();
        set_config(1'b1, 1'b0);
        send_text("@5 \t");
        send_text("@-5.25 ");
        send_text("@5. ");
        send_text("@5 1");
        send_text("@ 7\n");
    endtask

    task automatic test_random();
        int p;
        int start;
        for (p = 0; p < 6; p++)
        begin
            if (p < 4)
                set_config(p[0], p[1]);
            else
                set_config(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
            start = chars_sent;
            while (chars_sent - start < 258)
            begin
                build_literal();
                send_buf();
            end
        end
    endtask

    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_well_formed();
        test_syntax_errors();
        test_range();
        test_negative_fraction();
        test_trailing_space();
        test_random();
        wait_for_results();
        repeat (4) @(posedge clk);
        if (mismatches == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    initial
    begin
        #10ms;
        $display("Verification failed");
        $finish;
    end

endmodule

FILE: sim.f
rtl/elp_pkg.sv
rtl/elp_parse.sv
rtl/elp_finish.sv
rtl/epoch_literal_parser.sv
verif/tb_top.sv
